FILE: rtl/ifr_pkg.sv
package ifr_pkg;

  // Field widths of the item and register interfaces.
  localparam int unsigned BOX_W      = 24;
  localparam int unsigned TEX_W      = 16;
  localparam int unsigned ALIGN_W    = 16;
  localparam int unsigned SRC_W      = 17;
  localparam int unsigned DST_W      = 32;
  localparam int unsigned FIT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // A box length times a texture length.
  localparam int unsigned PROD_W = BOX_W + TEX_W;

  // Defaults of the top level parameters.
  localparam int unsigned SUBPIXEL_BITS_DEF = 8;
  localparam int unsigned NORM_BITS_DEF     = 16;

  // Fit mode codes held in the fit mode register.
  typedef enum logic [FIT_W-1:0] {
    FIT_FILL       = 3'd0,
    FIT_CONTAIN    = 3'd1,
    FIT_COVER      = 3'd2,
    FIT_WIDTH      = 3'd3,
    FIT_HEIGHT     = 3'd4,
    FIT_NONE       = 3'd5,
    FIT_SCALE_DOWN = 3'd6
  } fit_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_W   = 3'd0,
    REG_TEX_H   = 3'd1,
    REG_FIT     = 3'd2,
    REG_ALIGN_X = 3'd3,
    REG_ALIGN_Y = 3'd4
  } cfg_reg_e;

  // Per-item context that travels alongside the divider lanes.
  typedef struct packed {
    logic        [BOX_W-1:0] bw;
    logic        [BOX_W-1:0] bh;
    logic signed [BOX_W-1:0] ox;
    logic signed [BOX_W-1:0] oy;
    fit_e                    mode;
    logic                    le;
    logic                    ge;
  } item_t;

endpackage

FILE: rtl/ifr_div_pipe.sv
module ifr_div_pipe #(
  parameter int unsigned NORM_BITS = ifr_pkg::NORM_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  ifr_pkg::item_t                                 in_item_i,
  input  logic [ifr_pkg::PROD_W+NORM_BITS-1:0]           dvd_x_i,
  input  logic [ifr_pkg::PROD_W-1:0]                     dvs_x_i,
  input  logic [ifr_pkg::PROD_W+NORM_BITS-1:0]           dvd_y_i,
  input  logic [ifr_pkg::PROD_W-1:0]                     dvs_y_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output ifr_pkg::item_t                                 out_item_o,
  output logic [ifr_pkg::PROD_W+NORM_BITS-1:0]           quo_x_o,
  output logic [ifr_pkg::PROD_W+NORM_BITS-1:0]           quo_y_o
);

  localparam int unsigned PW = ifr_pkg::PROD_W;
  localparam int unsigned DW = PW + NORM_BITS;

  // One restoring division lane: the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  typedef struct packed {
    logic [DW-1:0] rq;
    logic [PW-1:0] rem;
    logic [PW-1:0] dvs;
  } lane_t;

  function automatic lane_t div_step(lane_t l);
    logic [PW:0] t;
    logic        take;
    lane_t       r;
    t     = {l.rem, l.rq[DW-1]};
    take  = (t >= {1'b0, l.dvs});
    r.dvs = l.dvs;
    r.rem = take ? PW'(t - {1'b0, l.dvs}) : t[PW-1:0];
    r.rq  = {l.rq[DW-2:0], take};
    return r;
  endfunction

  lane_t          lane_x [DW];
  lane_t          lane_y [DW];
  ifr_pkg::item_t item   [DW];
  logic           vld    [DW];
  logic           rdy    [DW];

  // One quotient bit per stage, DW stages in a row.
  for (genvar k = 0; k < DW; k++) begin : g_stage
    lane_t          lx_in;
    lane_t          ly_in;
    ifr_pkg::item_t it_in;
    logic           v_in;
    lane_t          lx_q;
    lane_t          ly_q;
    ifr_pkg::item_t it_q;
    logic           v_q;

    if (k == 0) begin : g_first
      assign lx_in = '{rq: dvd_x_i, rem: '0, dvs: dvs_x_i};
      assign ly_in = '{rq: dvd_y_i, rem: '0, dvs: dvs_y_i};
      assign it_in = in_item_i;
      assign v_in  = in_valid_i;
    end else begin : g_next
      assign lx_in = lane_x[k-1];
      assign ly_in = lane_y[k-1];
      assign it_in = item[k-1];
      assign v_in  = vld[k-1];
    end

    if (k == DW - 1) begin : g_last
      assign rdy[k] = !v_q || out_ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q || rdy[k+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        lx_q <= div_step(lx_in);
        ly_q <= div_step(ly_in);
        it_q <= it_in;
      end
    end

    assign lane_x[k] = lx_q;
    assign lane_y[k] = ly_q;
    assign item[k]   = it_q;
    assign vld[k]    = v_q;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld[DW-1];
  assign out_item_o  = item[DW-1];
  assign quo_x_o     = lane_x[DW-1].rq;
  assign quo_y_o     = lane_y[DW-1].rq;

endmodule

FILE: rtl/image_fit_rect_calculator.sv
// Image fit rectangle calculator. Each input transfer carries a box size and
// position; the texture size, fit mode and alignment come from the write
// port, which must only be written while no item is in flight. The block is a
// fully pipelined datapath that accepts one item per clock unless a stall has
// backed up to the input: one stage forms the cross products, one selects the
// mode and divider operands, 24 + 16 + NORM_BITS stages run two restoring
// dividers side by side at one quotient bit each, and three more stages pick
// the sizes, multiply by the alignment factor and saturate into the output
// register. Items with a zero box or texture size are taken and produce no
// result. Stalls propagate stage by stage, so empty stages keep filling while
// a result waits.
module image_fit_rect_calculator #(
  parameter int unsigned SUBPIXEL_BITS = ifr_pkg::SUBPIXEL_BITS_DEF,
  parameter int unsigned NORM_BITS     = ifr_pkg::NORM_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [ifr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [ifr_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [ifr_pkg::BOX_W-1:0]      box_width_i,
  input  logic        [ifr_pkg::BOX_W-1:0]      box_height_i,
  input  logic signed [ifr_pkg::BOX_W-1:0]      offset_x_i,
  input  logic signed [ifr_pkg::BOX_W-1:0]      offset_y_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [ifr_pkg::SRC_W-1:0]      src_left_o,
  output logic        [ifr_pkg::SRC_W-1:0]      src_top_o,
  output logic        [ifr_pkg::SRC_W-1:0]      src_width_o,
  output logic        [ifr_pkg::SRC_W-1:0]      src_height_o,
  output logic signed [ifr_pkg::DST_W-1:0]      dst_left_o,
  output logic signed [ifr_pkg::DST_W-1:0]      dst_top_o,
  output logic        [ifr_pkg::DST_W-1:0]      dst_width_o,
  output logic        [ifr_pkg::DST_W-1:0]      dst_height_o,
  output logic                                  clip_flag_o
);

  localparam int unsigned PW       = ifr_pkg::PROD_W;
  localparam int unsigned DW       = PW + NORM_BITS;
  localparam int unsigned BW       = ifr_pkg::BOX_W;
  localparam int unsigned TWS_W    = ifr_pkg::TEX_W + SUBPIXEL_BITS;
  localparam int unsigned NW       = NORM_BITS + 1;
  localparam int unsigned FAC_W    = ifr_pkg::ALIGN_W + 1;
  localparam int unsigned MUL_W    = PW + 1 + FAC_W;
  localparam int unsigned SHIFT    = 15;
  localparam int unsigned DST_W    = ifr_pkg::DST_W;
  localparam logic [NW-1:0] FULL   = NW'(1) << NORM_BITS;
  localparam logic signed [ifr_pkg::ALIGN_W-1:0] A_MAX = 16'sd16384;
  localparam logic signed [ifr_pkg::ALIGN_W-1:0] A_MIN = -16'sd16384;
  localparam logic signed [MUL_W-1:0] BIAS    = MUL_W'((1 << SHIFT) - 1);
  localparam logic signed [MUL_W-1:0] S32_MAX = MUL_W'(64'sh7FFF_FFFF);
  localparam logic signed [MUL_W-1:0] S32_MIN = -S32_MAX - MUL_W'(1);

  // Alignment factor 1 + align in Q1.14 after clamping, 0 to 32768.
  function automatic logic signed [FAC_W-1:0] align_fac(logic signed [15:0] a);
    logic signed [15:0] c;
    c = (a > A_MAX) ? A_MAX : ((a < A_MIN) ? A_MIN : a);
    return FAC_W'(c) + FAC_W'(A_MAX);
  endfunction

  // Configuration registers.
  logic [ifr_pkg::TEX_W-1:0]          tex_w_q, tex_h_q;
  logic [ifr_pkg::FIT_W-1:0]          fit_q;
  logic signed [ifr_pkg::ALIGN_W-1:0] align_x_q, align_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q   <= '0;
      tex_h_q   <= '0;
      fit_q     <= '0;
      align_x_q <= '0;
      align_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifr_pkg::REG_TEX_W:   tex_w_q   <= cfg_data_i[ifr_pkg::TEX_W-1:0];
        ifr_pkg::REG_TEX_H:   tex_h_q   <= cfg_data_i[ifr_pkg::TEX_W-1:0];
        ifr_pkg::REG_FIT:     fit_q     <= cfg_data_i[ifr_pkg::FIT_W-1:0];
        ifr_pkg::REG_ALIGN_X: align_x_q <= cfg_data_i;
        ifr_pkg::REG_ALIGN_Y: align_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Texture size in subpixel units.
  logic [TWS_W-1:0] tws, ths;
  assign tws = TWS_W'(tex_w_q) << SUBPIXEL_BITS;
  assign ths = TWS_W'(tex_h_q) << SUBPIXEL_BITS;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, dv_ready;

  // Stage A: capture the box and form both cross products.
  logic                 a_vld_q, a_nz;
  logic [BW-1:0]        a_bw_q, a_bh_q;
  logic signed [BW-1:0] a_ox_q, a_oy_q;
  logic [PW-1:0]        a_pthbw_q, a_ptwbh_q, a_pthbw_d, a_ptwbh_d;

  assign a_nz      = (|box_width_i) && (|box_height_i) && (|tex_w_q) && (|tex_h_q);
  assign a_pthbw_d = tex_h_q * box_width_i;
  assign a_ptwbh_d = tex_w_q * box_height_i;
  assign rdy_a     = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (rdy_a) begin
      a_vld_q <= in_valid_i && a_nz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_bw_q    <= box_width_i;
      a_bh_q    <= box_height_i;
      a_ox_q    <= offset_x_i;
      a_oy_q    <= offset_y_i;
      a_pthbw_q <= a_pthbw_d;
      a_ptwbh_q <= a_ptwbh_d;
    end
  end

  // Stage B: resolve the mode, compare aspect ratios, set divider operands.
  ifr_pkg::fit_e  b_mode_d;
  ifr_pkg::item_t b_item_d, b_item_q;
  logic           b_vld_q, b_frac, b_fits;
  logic [DW-1:0]  b_dvd_x_d, b_dvd_y_d, b_dvd_x_q, b_dvd_y_q;
  logic [PW-1:0]  b_dvs_x_d, b_dvs_y_d, b_dvs_x_q, b_dvs_y_q;

  assign b_fits = (PW'(tws) <= PW'(a_bw_q)) && (PW'(ths) <= PW'(a_bh_q));

  always_comb begin
    case (fit_q)
      ifr_pkg::FIT_CONTAIN, ifr_pkg::FIT_COVER, ifr_pkg::FIT_WIDTH,
      ifr_pkg::FIT_HEIGHT, ifr_pkg::FIT_NONE: begin
        b_mode_d = ifr_pkg::fit_e'(fit_q);
      end
      ifr_pkg::FIT_SCALE_DOWN: begin
        b_mode_d = b_fits ? ifr_pkg::FIT_NONE : ifr_pkg::FIT_CONTAIN;
      end
      default: begin
        b_mode_d = ifr_pkg::FIT_FILL;
      end
    endcase
  end

  assign b_frac = (b_mode_d == ifr_pkg::FIT_COVER);

  always_comb begin
    b_item_d.bw   = a_bw_q;
    b_item_d.bh   = a_bh_q;
    b_item_d.ox   = a_ox_q;
    b_item_d.oy   = a_oy_q;
    b_item_d.mode = b_mode_d;
    b_item_d.le   = (a_pthbw_q <= a_ptwbh_q);
    b_item_d.ge   = (a_pthbw_q >= a_ptwbh_q);
    // Cover divides one product by the other for a crop fraction; the other
    // modes divide a product by a texture length for a drawn size.
    if (b_frac) begin
      b_dvd_x_d = DW'(a_pthbw_q) << NORM_BITS;
      b_dvs_x_d = a_ptwbh_q;
      b_dvd_y_d = DW'(a_ptwbh_q) << NORM_BITS;
      b_dvs_y_d = a_pthbw_q;
    end else begin
      b_dvd_x_d = DW'(a_ptwbh_q);
      b_dvs_x_d = PW'(tex_h_q);
      b_dvd_y_d = DW'(a_pthbw_q);
      b_dvs_y_d = PW'(tex_w_q);
    end
  end

  assign rdy_b = !b_vld_q || dv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (rdy_b) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_vld_q) begin
      b_item_q  <= b_item_d;
      b_dvd_x_q <= b_dvd_x_d;
      b_dvs_x_q <= b_dvs_x_d;
      b_dvd_y_q <= b_dvd_y_d;
      b_dvs_y_q <= b_dvs_y_d;
    end
  end

  // Divider pipeline.
  logic           dv_vld;
  ifr_pkg::item_t dv_item;
  logic [DW-1:0]  dv_qx, dv_qy;

  ifr_div_pipe #(
    .NORM_BITS (NORM_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_vld_q),
    .in_ready_o  (dv_ready),
    .in_item_i   (b_item_q),
    .dvd_x_i     (b_dvd_x_q),
    .dvs_x_i     (b_dvs_x_q),
    .dvd_y_i     (b_dvd_y_q),
    .dvs_y_i     (b_dvs_y_q),
    .out_valid_o (dv_vld),
    .out_ready_i (rdy_c),
    .out_item_o  (dv_item),
    .quo_x_o     (dv_qx),
    .quo_y_o     (dv_qy)
  );

  // Stage C: pick the drawn size, clip flag and multiplier operands.
  logic                 c_vld_q;
  logic signed [BW-1:0] c_ox_q, c_oy_q;
  logic [PW-1:0]        c_dw_d, c_dh_d, c_dw_q, c_dh_q;
  logic                 c_clip_d, c_clip_q, c_cover_d, c_cover_q, c_aligned;
  logic [NW-1:0]        c_sw_d, c_sh_d, c_sw_q, c_sh_q, c_fx, c_fy;
  logic signed [PW:0]   c_opx_d, c_opy_d, c_opx_q, c_opy_q;
  logic [PW-1:0]        c_bw, c_bh, c_qx, c_qy;

  assign c_bw = PW'(dv_item.bw);
  assign c_bh = PW'(dv_item.bh);
  assign c_qx = dv_qx[PW-1:0];
  assign c_qy = dv_qy[PW-1:0];
  // A crop fraction of one or more means the full texture.
  assign c_fx = (|dv_qx[DW-1:NORM_BITS]) ? FULL : NW'(dv_qx[NORM_BITS-1:0]);
  assign c_fy = (|dv_qy[DW-1:NORM_BITS]) ? FULL : NW'(dv_qy[NORM_BITS-1:0]);

  always_comb begin
    c_dw_d    = c_bw;
    c_dh_d    = c_bh;
    c_clip_d  = 1'b0;
    c_cover_d = 1'b0;
    c_aligned = 1'b0;
    c_sw_d    = FULL;
    c_sh_d    = FULL;
    case (dv_item.mode)
      ifr_pkg::FIT_CONTAIN: begin
        c_aligned = 1'b1;
        if (dv_item.le) begin
          c_dh_d = c_qy;
        end else begin
          c_dw_d = c_qx;
        end
      end
      ifr_pkg::FIT_COVER: begin
        c_cover_d = 1'b1;
        if (dv_item.ge) begin
          c_sh_d = c_fy;
        end else begin
          c_sw_d = c_fx;
        end
      end
      ifr_pkg::FIT_WIDTH: begin
        c_aligned = 1'b1;
        c_dh_d    = c_qy;
        c_clip_d  = (c_qy > c_bh);
      end
      ifr_pkg::FIT_HEIGHT: begin
        c_aligned = 1'b1;
        c_dw_d    = c_qx;
        c_clip_d  = (c_qx > c_bw);
      end
      ifr_pkg::FIT_NONE: begin
        c_aligned = 1'b1;
        c_dw_d    = PW'(tws);
        c_dh_d    = PW'(ths);
        c_clip_d  = (PW'(tws) > c_bw) || (PW'(ths) > c_bh);
      end
      default: ;
    endcase
  end

  // Placement multiplies the leftover length; cover multiplies the crop.
  always_comb begin
    if (c_aligned) begin
      c_opx_d = {1'b0, c_bw} - {1'b0, c_dw_d};
      c_opy_d = {1'b0, c_bh} - {1'b0, c_dh_d};
    end else if (c_cover_d) begin
      c_opx_d = (PW + 1)'(FULL - c_sw_d);
      c_opy_d = (PW + 1)'(FULL - c_sh_d);
    end else begin
      c_opx_d = '0;
      c_opy_d = '0;
    end
  end

  assign rdy_c = !c_vld_q || rdy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (rdy_c) begin
      c_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && dv_vld) begin
      c_ox_q    <= dv_item.ox;
      c_oy_q    <= dv_item.oy;
      c_dw_q    <= c_dw_d;
      c_dh_q    <= c_dh_d;
      c_clip_q  <= c_clip_d;
      c_cover_q <= c_cover_d;
      c_sw_q    <= c_sw_d;
      c_sh_q    <= c_sh_d;
      c_opx_q   <= c_opx_d;
      c_opy_q   <= c_opy_d;
    end
  end

  // Stage D: multiply by the alignment factor.
  logic                    d_vld_q;
  logic signed [BW-1:0]    d_ox_q, d_oy_q;
  logic [PW-1:0]           d_dw_q, d_dh_q;
  logic                    d_clip_q, d_cover_q;
  logic [NW-1:0]           d_sw_q, d_sh_q;
  logic signed [FAC_W-1:0] d_fax, d_fay;
  logic signed [MUL_W-1:0] d_prodx_d, d_prody_d, d_prodx_q, d_prody_q;

  assign d_fax     = align_fac(align_x_q);
  assign d_fay     = align_fac(align_y_q);
  assign d_prodx_d = c_opx_q * d_fax;
  assign d_prody_d = c_opy_q * d_fay;
  assign rdy_d     = !d_vld_q || rdy_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (rdy_d) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_vld_q) begin
      d_ox_q    <= c_ox_q;
      d_oy_q    <= c_oy_q;
      d_dw_q    <= c_dw_q;
      d_dh_q    <= c_dh_q;
      d_clip_q  <= c_clip_q;
      d_cover_q <= c_cover_q;
      d_sw_q    <= c_sw_q;
      d_sh_q    <= c_sh_q;
      d_prodx_q <= d_prodx_d;
      d_prody_q <= d_prody_d;
    end
  end

  // Stage E: scale back toward zero, add the offset, saturate.
  logic signed [MUL_W-1:0] e_qx, e_qy, e_px, e_py, e_sumx, e_sumy;
  logic                    e_vld_q;

  assign e_qx = (d_prodx_q < 0) ? ((d_prodx_q + BIAS) >>> SHIFT) : (d_prodx_q >>> SHIFT);
  assign e_qy = (d_prody_q < 0) ? ((d_prody_q + BIAS) >>> SHIFT) : (d_prody_q >>> SHIFT);
  assign e_px = d_cover_q ? '0 : e_qx;
  assign e_py = d_cover_q ? '0 : e_qy;
  assign e_sumx = MUL_W'(d_ox_q) + e_px;
  assign e_sumy = MUL_W'(d_oy_q) + e_py;
  assign rdy_e  = !e_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (rdy_e) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && d_vld_q) begin
      src_left_o   <= d_cover_q ? ifr_pkg::SRC_W'(e_qx) : '0;
      src_top_o    <= d_cover_q ? ifr_pkg::SRC_W'(e_qy) : '0;
      src_width_o  <= ifr_pkg::SRC_W'(d_sw_q);
      src_height_o <= ifr_pkg::SRC_W'(d_sh_q);
      dst_left_o   <= (e_sumx > S32_MAX) ? DST_W'(S32_MAX) :
                      (e_sumx < S32_MIN) ? DST_W'(S32_MIN) : DST_W'(e_sumx);
      dst_top_o    <= (e_sumy > S32_MAX) ? DST_W'(S32_MAX) :
                      (e_sumy < S32_MIN) ? DST_W'(S32_MIN) : DST_W'(e_sumy);
      dst_width_o  <= (|d_dw_q[PW-1:DST_W]) ? '1 : d_dw_q[DST_W-1:0];
      dst_height_o <= (|d_dh_q[PW-1:DST_W]) ? '1 : d_dh_q[DST_W-1:0];
      clip_flag_o  <= d_clip_q;
    end
  end

  assign out_valid_o = e_vld_q;

  // A clipped result never carries a crop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clip_flag_o |->
      (src_left_o == '0) && (src_top_o == '0) &&
      (src_width_o == ifr_pkg::SRC_W'(FULL)) && (src_height_o == ifr_pkg::SRC_W'(FULL)))
    else $error("clipped result carries a source crop");

  // A cover crop acts on one axis only and keeps the box size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (src_width_o != ifr_pkg::SRC_W'(FULL)) |->
      (src_top_o == '0) && (src_height_o == ifr_pkg::SRC_W'(FULL)) && !clip_flag_o)
    else $error("horizontal crop with vertical crop or clip");

  // A stalled stage holds its item until the next stage takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && !rdy_d |=> c_vld_q && $stable(c_opx_q) && $stable(c_dw_q))
    else $error("stage C lost an item under stall");

endmodule

FILE: tb/image_fit_rect_calculator_tb.sv
`timescale 1ns / 1ps

module image_fit_rect_calculator_tb;
  import ifr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned LONG_HOLD      = 300;
  localparam logic [FIT_W-1:0] FIT_UNUSED = 3'd7;

  // Kinds of directed rows: predicted, typed result, typed no result.
  localparam int ROW_PREDICT = 0;
  localparam int ROW_TYPED   = 1;
  localparam int ROW_NONE    = 2;

  typedef struct {
    logic [SRC_W-1:0] src_left;
    logic [SRC_W-1:0] src_top;
    logic [SRC_W-1:0] src_width;
    logic [SRC_W-1:0] src_height;
    logic [DST_W-1:0] dst_left;
    logic [DST_W-1:0] dst_top;
    logic [DST_W-1:0] dst_width;
    logic [DST_W-1:0] dst_height;
    logic             clip_flag;
  } fit_rect_t;

  typedef struct {
    logic [TEX_W-1:0]   tex_w;
    logic [TEX_W-1:0]   tex_h;
    logic [FIT_W-1:0]   fit;
    logic [ALIGN_W-1:0] align_x;
    logic [ALIGN_W-1:0] align_y;
    logic [BOX_W-1:0]   bw;
    logic [BOX_W-1:0]   bh;
    logic [BOX_W-1:0]   ox;
    logic [BOX_W-1:0]   oy;
    int                 kind;
    fit_rect_t          rect;
  } box_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [BOX_W-1:0] box_width_i = '0;
  logic [BOX_W-1:0] box_height_i = '0;
  logic signed [BOX_W-1:0] offset_x_i = '0;
  logic signed [BOX_W-1:0] offset_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SRC_W-1:0] src_left_o, src_top_o, src_width_o, src_height_o;
  logic signed [DST_W-1:0] dst_left_o, dst_top_o;
  logic [DST_W-1:0] dst_width_o, dst_height_o;
  logic clip_flag_o;

  image_fit_rect_calculator dut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [TEX_W-1:0]          shadow_tex_w = '0;
  logic [TEX_W-1:0]          shadow_tex_h = '0;
  logic [FIT_W-1:0]          shadow_fit = '0;
  logic signed [ALIGN_W-1:0] shadow_align_x = '0;
  logic signed [ALIGN_W-1:0] shadow_align_y = '0;

  fit_rect_t pending_rects[$];
  box_row_t  box_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int setups_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint clamp_align(logic signed [ALIGN_W-1:0] a);
    longint v;
    v = a;
    if (v < -16384) v = -16384;
    if (v > 16384) v = 16384;
    return v;
  endfunction

  // Visible fraction floor(num / den * 2^16), capped at the full size.
  function automatic longint unsigned visible_fraction(longint unsigned num,
                                                       longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = num;
    if (num >= den) return 64'd1 << 16;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint align_offset(longint unsigned box, longint unsigned drawn,
                                          longint a);
    longint diff;
    diff = longint'(box) - longint'(drawn);
    return (diff * (16384 + a)) / 32768;
  endfunction

  function automatic logic [DST_W-1:0] sat_signed(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[DST_W-1:0];
  endfunction

  function automatic logic [DST_W-1:0] sat_unsigned(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[DST_W-1:0];
  endfunction

  // Computes the placement of one box under the shadow configuration.
  function automatic bit fit_box(input logic [BOX_W-1:0] bw_in, input logic [BOX_W-1:0] bh_in,
                                 input logic signed [BOX_W-1:0] ox_in,
                                 input logic signed [BOX_W-1:0] oy_in, output fit_rect_t r);
    longint unsigned bw, bh, tw, th, tws, ths, dw, dh, sl, st, sw, sh, full;
    longint ax, ay, px, py, ox, oy;
    bit clip, aligned;
    logic [FIT_W-1:0] mode;
    bw = bw_in;
    bh = bh_in;
    ox = ox_in;
    oy = oy_in;
    tw = shadow_tex_w;
    th = shadow_tex_h;
    tws = tw << 8;
    ths = th << 8;
    ax = clamp_align(shadow_align_x);
    ay = clamp_align(shadow_align_y);
    full = 64'd1 << 16;
    sl = 0;
    st = 0;
    sw = full;
    sh = full;
    dw = bw;
    dh = bh;
    px = 0;
    py = 0;
    clip = 1'b0;
    aligned = 1'b0;
    mode = shadow_fit;
    r = '{default: '0};
    if (bw == 0 || bh == 0 || tw == 0 || th == 0) return 1'b0;
    // Scale down acts as none when the texture already fits, else as contain.
    if (mode == FIT_SCALE_DOWN) mode = (tws <= bw && ths <= bh) ? FIT_NONE : FIT_CONTAIN;
    case (mode)
      FIT_CONTAIN: begin
        if (bw * th <= bh * tw) begin
          dw = bw;
          dh = th * bw / tw;
        end else begin
          dh = bh;
          dw = tw * bh / th;
        end
        aligned = 1'b1;
      end
      FIT_COVER: begin
        if (bw * th >= bh * tw) begin
          sh = visible_fraction(bh * tw, th * bw);
          st = longint'((longint'(full - sh) * (16384 + ay)) / 32768);
        end else begin
          sw = visible_fraction(bw * th, tw * bh);
          sl = longint'((longint'(full - sw) * (16384 + ax)) / 32768);
        end
      end
      FIT_WIDTH: begin
        dh = th * bw / tw;
        clip = dh > bh;
        aligned = 1'b1;
      end
      FIT_HEIGHT: begin
        dw = tw * bh / th;
        clip = dw > bw;
        aligned = 1'b1;
      end
      FIT_NONE: begin
        dw = tws;
        dh = ths;
        clip = (dw > bw) || (dh > bh);
        aligned = 1'b1;
      end
      default: begin
      end
    endcase
    if (aligned) begin
      px = align_offset(bw, dw, ax);
      py = align_offset(bh, dh, ay);
    end
    r.src_left = sl[SRC_W-1:0];
    r.src_top = st[SRC_W-1:0];
    r.src_width = sw[SRC_W-1:0];
    r.src_height = sh[SRC_W-1:0];
    r.dst_left = sat_signed(ox + px);
    r.dst_top = sat_signed(oy + py);
    r.dst_width = sat_unsigned(dw);
    r.dst_height = sat_unsigned(dh);
    r.clip_flag = clip;
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_TEX_W:   shadow_tex_w = value;
      REG_TEX_H:   shadow_tex_h = value;
      REG_FIT:     shadow_fit = value[FIT_W-1:0];
      REG_ALIGN_X: shadow_align_x = value;
      REG_ALIGN_Y: shadow_align_y = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stops offering boxes until every expected result is back and the pipe is empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(logic [TEX_W-1:0] tw, logic [TEX_W-1:0] th,
                             logic [FIT_W-1:0] fit, logic [ALIGN_W-1:0] ax,
                             logic [ALIGN_W-1:0] ay);
    wait_drained();
    write_reg(REG_TEX_W, tw);
    write_reg(REG_TEX_H, th);
    write_reg(REG_FIT, CFG_DATA_W'(fit));
    write_reg(REG_ALIGN_X, ax);
    write_reg(REG_ALIGN_Y, ay);
    setups_done++;
  endtask

  // Offers one box; valid stays high afterwards so back-to-back transfers stay legal.
  task automatic send_box(logic [BOX_W-1:0] bw, logic [BOX_W-1:0] bh, logic [BOX_W-1:0] ox,
                          logic [BOX_W-1:0] oy, int kind, fit_rect_t typed);
    fit_rect_t r;
    bit has_result;
    has_result = fit_box(bw, bh, ox, oy, r);
    if (kind == ROW_TYPED) begin
      has_result = 1'b1;
      r = typed;
    end else if (kind == ROW_NONE) begin
      has_result = 1'b0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    box_width_i <= bw;
    box_height_i <= bh;
    offset_x_i <= ox;
    offset_y_i <= oy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (has_result) pending_rects.push_back(r);
    items_sent++;
  endtask

  function automatic logic [BOX_W-1:0] pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 3) return '0;
    if (sel < 8) return '1;
    if (sel < 40) return BOX_W'($urandom_range(1, 16'h3FFF));
    if (sel < 70) return BOX_W'($urandom_range(1, 20'hFFFFF));
    return BOX_W'($urandom);
  endfunction

  function automatic logic [TEX_W-1:0] pick_texture();
    case ($urandom_range(4))
      0: return TEX_W'($urandom_range(1, 16));
      1: return TEX_W'($urandom_range(1, 400));
      2: return '1;
      3: return TEX_W'($urandom);
      default: return TEX_W'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic logic [ALIGN_W-1:0] pick_align();
    case ($urandom_range(5))
      0: return -16'sd16384;
      1: return 16'sd16384;
      2: return '0;
      3: return ALIGN_W'($urandom);
      default: return ALIGN_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic random_boxes(int count);
    fit_rect_t none;
    none = '{default: '0};
    repeat (count)
      send_box(pick_length(), pick_length(), BOX_W'($urandom), BOX_W'($urandom),
               ROW_PREDICT, none);
  endtask

  function automatic void add_row(logic [TEX_W-1:0] tw, logic [TEX_W-1:0] th,
                                  logic [FIT_W-1:0] fit, logic [ALIGN_W-1:0] ax,
                                  logic [ALIGN_W-1:0] ay, logic [BOX_W-1:0] bw,
                                  logic [BOX_W-1:0] bh, logic [BOX_W-1:0] ox,
                                  logic [BOX_W-1:0] oy, int kind, fit_rect_t rect);
    box_rows.push_back('{tw, th, fit, ax, ay, bw, bh, ox, oy, kind, rect});
  endfunction

  // Receiver side: random stalls plus an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checking and the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (out_valid_o && out_ready_i) begin
          results_seen++;
          if (pending_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
          end else begin
            fit_rect_t e;
            e = pending_rects.pop_front();
            if (e.src_left !== src_left_o || e.src_top !== src_top_o ||
                e.src_width !== src_width_o || e.src_height !== src_height_o ||
                e.dst_left !== dst_left_o || e.dst_top !== dst_top_o ||
                e.dst_width !== dst_width_o || e.dst_height !== dst_height_o ||
                e.clip_flag !== clip_flag_o) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("mismatch at %0t: expected src %h %h %h %h dst %h %h %h %h clip %b",
                         $realtime, e.src_left, e.src_top, e.src_width, e.src_height,
                         e.dst_left, e.dst_top, e.dst_width, e.dst_height, e.clip_flag);
                $display("               actual   src %h %h %h %h dst %h %h %h %h clip %b",
                         src_left_o, src_top_o, src_width_o, src_height_o, dst_left_o,
                         dst_top_o, dst_width_o, dst_height_o, clip_flag_o);
              end
            end
          end
        end
      end
    end
  end

  initial begin
    fit_rect_t none;
    none = '{default: '0};

    // After reset there is no texture, so nothing comes back.
    add_row(0, 0, FIT_FILL, 0, 0, 24'h000100, 24'h000100, 0, 0, ROW_NONE, none);
    add_row(4, 2, FIT_FILL, 0, 0, 24'h000100, 24'h000200, -24'sd5, 24'sd7, ROW_TYPED,
            '{0, 0, 17'h10000, 17'h10000, -32'sd5, 32'sd7, 32'h100, 32'h200, 1'b0});
    add_row(4, 2, FIT_FILL, 0, 0, 24'h000000, 24'h000200, 0, 0, ROW_NONE, none);
    add_row(4, 2, FIT_FILL, 0, 0, 24'h000100, 24'h000000, 0, 0, ROW_NONE, none);
    add_row(4, 2, FIT_FILL, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, ROW_TYPED,
            '{0, 0, 17'h10000, 17'h10000, 32'h007FFFFF, 32'hFF800000, 32'hFFFFFF,
              32'hFFFFFF, 1'b0});
    // The unused fit code behaves as fill.
    add_row(4, 2, FIT_UNUSED, 0, 0, 24'h000300, 24'h000500, 24'd1, 24'd2, ROW_TYPED,
            '{0, 0, 17'h10000, 17'h10000, 32'd1, 32'd2, 32'h300, 32'h500, 1'b0});
    add_row(0, 2, FIT_CONTAIN, 0, 0, 24'h000100, 24'h000100, 0, 0, ROW_NONE, none);
    add_row(2, 0, FIT_CONTAIN, 0, 0, 24'h000100, 24'h000100, 0, 0, ROW_NONE, none);
    add_row(4, 2, FIT_CONTAIN, 0, 0, 24'h000800, 24'h000200, 24'd10, 24'd20, ROW_PREDICT, none);
    add_row(4, 2, FIT_CONTAIN, 0, 0, 24'h000200, 24'h000800, 24'd10, 24'd20, ROW_PREDICT, none);
    add_row(640, 480, FIT_COVER, 16'sd16384, -16'sd16384, 24'h010000, 24'h001000, 0, 0,
            ROW_PREDICT, none);
    add_row(640, 480, FIT_COVER, -16'sd16384, 16'sd16384, 24'h001000, 24'h010000, 0, 0,
            ROW_PREDICT, none);
    // Alignment beyond one is clamped.
    add_row(640, 480, FIT_COVER, 16'h7FFF, 16'h8000, 24'h001000, 24'h010000, 0, 0,
            ROW_PREDICT, none);
    add_row(1, 65535, FIT_WIDTH, 0, 16'sd16384, 24'hFFFFFF, 24'h000001, 24'h800000,
            24'h800000, ROW_PREDICT, none);
    add_row(65535, 1, FIT_HEIGHT, 16'h8000, 0, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
            24'h7FFFFF, ROW_PREDICT, none);
    add_row(65535, 65535, FIT_NONE, 16'h7FFF, -16'sd16384, 24'h000100, 24'h000100, 0, 0,
            ROW_PREDICT, none);
    add_row(8, 8, FIT_NONE, 0, 0, 24'h000800, 24'h000800, 0, 0, ROW_PREDICT, none);
    add_row(8, 8, FIT_SCALE_DOWN, 0, 0, 24'h001000, 24'h002000, 0, 0, ROW_PREDICT, none);
    add_row(8, 8, FIT_SCALE_DOWN, 0, 0, 24'h000400, 24'h002000, 0, 0, ROW_PREDICT, none);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; the configuration is reloaded whenever a row asks for a new one.
    foreach (box_rows[i]) begin
      if (box_rows[i].tex_w != shadow_tex_w || box_rows[i].tex_h != shadow_tex_h ||
          box_rows[i].fit != shadow_fit || box_rows[i].align_x != shadow_align_x ||
          box_rows[i].align_y != shadow_align_y)
        load_config(box_rows[i].tex_w, box_rows[i].tex_h, box_rows[i].fit,
                    box_rows[i].align_x, box_rows[i].align_y);
      send_box(box_rows[i].bw, box_rows[i].bh, box_rows[i].ox, box_rows[i].oy,
               box_rows[i].kind, box_rows[i].rect);
    end

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int s = 0; s < 4; s++) begin
        load_config(pick_texture(), pick_texture(), FIT_W'($urandom_range(7)),
                    pick_align(), pick_align());
        // Once, hold the output off long enough to back the pipe up to the input.
        if (ph == 0 && s == 0) hold_requests++;
        random_boxes(100);
      end
    end

    wait_drained();
    $display("Sent %0d boxes over %0d register setups; checked %0d results.",
             items_sent, setups_done, results_seen);
    $display("All fit modes, alignment clamps, zero sizes and backpressure were exercised.");
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_rects.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
